// ===== rtl/core/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants of the wrapped table sum block
// Field widths, command codes and register indexes used by wts_sum and wrapped_table_sum.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned TOTAL_W  = 42;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Command codes carried by the opcode field.
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_LIST  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_EMPTY = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LEN = 1'b1;

  // Reset value of both length registers.
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

endpackage

`default_nettype wire

// ===== rtl/core/wts_ram.sv =====
// ----------------------------------------------------------------------------
// wts_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, otherwise read into the output register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wts_sum.sv =====
// ----------------------------------------------------------------------------
// wts_sum: wrapped walk over the table with one shared adder
// Reads one entry per cycle, wrapping the address at the active length,
// and accumulates the sign-extended entries into the total.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_sum #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]       top_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]       ml_i,
  output logic      [$clog2(DEPTH)-1:0]         rd_addr_o,
  input  wire logic [VALUE_BITS-1:0]            rd_data_i,
  output logic                                  done_o,
  output logic      [wts_pkg::TOTAL_W-1:0]      total_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    WS_IDLE = 3'b001,
    WS_RUN  = 3'b010,
    WS_DONE = 3'b100
  } wstate_e;

  wstate_e                     state_q, state_d;
  logic                        pend_q, pend_d;
  logic [CNT_W-1:0]            i_q, i_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [CNT_W-1:0]            top_q, top_d;
  logic [CNT_W-1:0]            ml_q, ml_d;
  logic [wts_pkg::TOTAL_W-1:0] acc_q, acc_d;
  logic                        issue;
  logic                        addr_wrap;

  assign issue     = (i_q != top_q);
  assign addr_wrap = ((CNT_W'(addr_q) + CNT_W'(1)) == ml_q);

  // Walk sequencer: issue one read per cycle, add the returned data in the following cycle.
  always_comb begin
    state_d = state_q;
    pend_d  = 1'b0;
    i_d     = i_q;
    addr_d  = addr_q;
    top_d   = top_q;
    ml_d    = ml_q;
    acc_d   = acc_q;
    if (start_i) begin
      state_d = WS_RUN;
      i_d     = '0;
      addr_d  = '0;
      top_d   = top_i;
      ml_d    = ml_i;
      acc_d   = '0;
    end else begin
      unique case (state_q) inside
        WS_IDLE, WS_DONE: begin
        end
        WS_RUN: begin
          if (pend_q) begin
            acc_d = acc_q + wts_pkg::TOTAL_W'($signed(rd_data_i));
          end
          if (issue) begin
            pend_d = 1'b1;
            i_d    = i_q + CNT_W'(1);
            addr_d = addr_wrap ? '0 : addr_q + AW'(1);
          end else if (!pend_q) begin
            state_d = WS_DONE;
          end
        end
        default: state_d = WS_IDLE;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // Walk counters and accumulator.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    addr_q <= addr_d;
    top_q  <= top_d;
    ml_q   <= ml_d;
    acc_q  <= acc_d;
  end

  assign rd_addr_o = addr_q;
  assign done_o    = (state_q == WS_DONE);
  assign total_o   = acc_q;

  // The position counter never runs past the end of the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_RUN) |-> (i_q <= top_q))
    else $error("walk counter passed its end");

  // The read address always stays inside the active length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_RUN) |-> (CNT_W'(addr_q) < ml_q))
    else $error("read address outside active length");

  // A start always opens a fresh walk with an empty accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (state_q == WS_RUN) && (acc_q == '0) && !pend_q)
    else $error("walk did not restart cleanly");

endmodule

`default_nettype wire

// ===== rtl/core/wrapped_table_sum.sv =====
// ----------------------------------------------------------------------------
// wrapped_table_sum: table of Q16.16 values with a wrapped running sum
// Command handling, count and load pointer, table memory and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_valid_i / in_ready_o channel; results leave on
//   out_valid_o / out_ready_i. Set, the last list element and the empty list
//   each produce one item with the wrapped total and the entry count; clear,
//   other list elements and a set at position zero produce none.
//   A command that writes without summing keeps in_ready_o high. A summing
//   command walks top = min(count, limit) entries, one memory read per cycle
//   through the single adder; the single-port table memory sets that rate.
//   in_ready_o stays low until its result enters the output register.
//   After reset and after a clear command the block sweeps the table to
//   zero, one entry per cycle over all DEPTH entries, with in_ready_o low.
//   Configuration writes are taken at any time and are meant for idle
//   periods. A finished result waits in the output register while the
//   receiver stalls; the next command is accepted meanwhile, and its own
//   result holds inside the block until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_table_sum #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [wts_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  wire logic [wts_pkg::CFG_W-1:0]          cfg_wdata_i,
  // Command channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic [wts_pkg::POS_W-1:0]          position_i,
  input  wire logic signed [wts_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                               last_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [wts_pkg::TOTAL_W-1:0]      total_o,
  output logic      [wts_pkg::LEN_W-1:0]          length_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_START = 4'b0100,
    ST_SUM   = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            used_q, used_d;
  logic [CNT_W-1:0]            ptr_q, ptr_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [wts_pkg::CFG_W-1:0]   max_len_q, wrap_len_q;
  logic                        out_valid_q;
  logic [wts_pkg::TOTAL_W-1:0] total_q;
  logic [wts_pkg::LEN_W-1:0]   length_q;

  logic                        accept;
  wts_pkg::op_e                op;
  logic                        set_ok;
  logic                        ptr_room;
  logic [CNT_W-1:0]            ptr_next;
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [VALUE_BITS-1:0]       ram_wdata;
  logic [VALUE_BITS-1:0]       ram_rdata;
  logic [VALUE_BITS-1:0]       value;
  logic [CNT_W-1:0]            ml, wl, limit, top;
  logic                        sum_start;
  logic [AW-1:0]               sum_addr;
  logic                        sum_done;
  logic [wts_pkg::TOTAL_W-1:0] sum_total;
  logic                        out_free;
  logic                        out_load;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign op        = wts_pkg::op_e'(opcode_i);
  assign value     = VALUE_BITS'(sample_i);
  assign set_ok    = (position_i != '0) && (32'(position_i) <= 32'(DEPTH));
  assign ptr_room  = (ptr_q < CNT_W'(DEPTH));
  assign ptr_next  = ptr_q + CNT_W'(ptr_room);

  // Active lengths from the registers, clamped into range.
  always_comb begin
    if (max_len_q == '0) begin
      ml = CNT_W'(1);
    end else if (32'(max_len_q) > 32'(DEPTH)) begin
      ml = CNT_W'(DEPTH);
    end else begin
      ml = CNT_W'(max_len_q);
    end
    if (32'(wrap_len_q) > 32'(DEPTH)) begin
      wl = CNT_W'(DEPTH);
    end else begin
      wl = CNT_W'(wrap_len_q);
    end
    limit = (wl > ml) ? wl : ml;
    top   = (used_q < limit) ? used_q : limit;
  end

  // Table port: clearing sweep, command writes, otherwise walk reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = sum_addr;
    ram_wdata = value;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else if (accept && (op == wts_pkg::OP_SET) && set_ok) begin
      ram_we   = 1'b1;
      ram_addr = AW'(position_i - wts_pkg::POS_W'(1));
    end else if (accept && (op == wts_pkg::OP_LIST) && ptr_room) begin
      ram_we   = 1'b1;
      ram_addr = ptr_q[AW-1:0];
    end
  end

  // Result register frees up when empty or when its item leaves.
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_SUM) && sum_done && out_free;

  // Command sequencer.
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    ptr_d   = ptr_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            wts_pkg::OP_SET: begin
              if (set_ok) begin
                if (32'(position_i) > 32'(used_q)) begin
                  used_d = CNT_W'(position_i);
                end
                state_d = ST_START;
              end
            end
            wts_pkg::OP_LIST: begin
              ptr_d = ptr_next;
              if (last_i) begin
                used_d  = ptr_next;
                ptr_d   = '0;
                state_d = ST_START;
              end
            end
            wts_pkg::OP_CLEAR: begin
              used_d  = CNT_W'(1);
              ptr_d   = '0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            wts_pkg::OP_EMPTY: begin
              used_d  = '0;
              ptr_d   = '0;
              state_d = ST_START;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_START: state_d = ST_SUM;
      ST_SUM: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign sum_start = (state_q == ST_START);

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      used_q      <= CNT_W'(1);
      ptr_q       <= '0;
      clr_q       <= '0;
      max_len_q   <= wts_pkg::CFG_RESET;
      wrap_len_q  <= wts_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          wts_pkg::REG_MAX_LEN:  max_len_q  <= cfg_wdata_i;
          wts_pkg::REG_WRAP_LEN: wrap_len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      total_q  <= sum_total;
      length_q <= wts_pkg::LEN_W'(used_q);
    end
  end

  wts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  wts_sum #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_sum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sum_start),
    .top_i     (top),
    .ml_i      (ml),
    .rd_addr_o (sum_addr),
    .rd_data_i (ram_rdata),
    .done_o    (sum_done),
    .total_o   (sum_total)
  );

  assign out_valid_o = out_valid_q;
  assign total_o     = total_q;
  assign length_o    = length_q;

  // The entry count and the load pointer never pass the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q <= CNT_W'(DEPTH)) && (ptr_q <= CNT_W'(DEPTH)))
    else $error("count or load pointer beyond table depth");

  // A clear command starts the sweep with a count of one and no partial list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == wts_pkg::OP_CLEAR)) |=>
      (state_q == ST_CLEAR) && (used_q == CNT_W'(1)) && (ptr_q == '0))
    else $error("clear command did not reset the table state");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("result register overwritten while stalled");

  // The walk never touches the table while a write is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_IDLE)))
    else $error("table write outside of idle or clearing");

endmodule

`default_nettype wire
